/* src/smdf_pkg.sv */
// ----------------------------------------------------------------------------
// smdf_pkg
// Shared types and fixed constants of the stereo modulated delay flanger.
// ----------------------------------------------------------------------------
package smdf_pkg;

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_LFO_STEP  = 3'd0,
        CFG_FB_GAIN   = 3'd1,
        CFG_MOD_DEPTH = 3'd2,
        CFG_WET_MIX   = 3'd3,
        CFG_DELAY_LEN = 3'd4
    } t_cfg_idx;

    localparam int CFG_AW = 3;
    localparam int CFG_DW = 31;

    // shared multiplier operand width (signed)
    localparam int MUL_W = 33;

    // quarter-wave sine polynomial, Q30 coefficients
    localparam logic [30:0] CO1 = 31'd1686629713;
    localparam logic [30:0] CO3 = 31'd693598670;
    localparam logic [30:0] CO5 = 31'd85569306;
    localparam logic [30:0] CO7 = 31'd5026995;
    localparam logic [30:0] Q30_ONE = 31'd1073741824;

    // ceil(2^32 / 5): exact floor(a/5) for a below 2^29
    localparam logic [29:0] DIV5_MAGIC = 30'd858993460;

    localparam logic [15:0] GAIN_MAX = 16'd62259;
    localparam logic [16:0] Q16_ONE  = 17'd65536;
    localparam logic [16:0] Q16_HALF = 17'd32768;

endpackage

/* src/stereo_modulated_delay_flanger_top.sv */
// Flow: a request is accepted in idle; its result is valid in S_OUT after the
//   steps S_INC to S_SUM (bypass, delay length 0: straight from idle to S_OUT).
// Sharing: a new request is accepted only after the result is taken; one shared
//   multiplier runs the sine polynomial, the delay product, feedback and mix in turn.
// Reset: synchronous active low; then a clearing pass over all 2*DELAY_DEPTH
//   entries zeroes the delay memory while no request is accepted.
// ----------------------------------------------------------------------------
// stereo_modulated_delay_flanger_top
// Stereo feedback flanger: per-channel sine LFO modulated delay with feedback
// and dry/wet mix, computed by a sequencer around one multiplier.
// ----------------------------------------------------------------------------
module stereo_modulated_delay_flanger_top #(
    parameter int DELAY_DEPTH      = 4096,
    parameter int SAMPLE_BITS      = 24,
    parameter int SINE_TABLE_DEPTH = 1024   // power of two
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // [SAMPLE_BITS-1:0] sample_in, zero padded to bytes
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0] s_axis_tdata,
    // [0] channel
    input  logic                            s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [SAMPLE_BITS-1:0] sample_out, zero padded to bytes
    output logic [((SAMPLE_BITS+7)/8)*8-1:0] m_axis_tdata,
    // [0] channel_out
    output logic                            m_axis_tuser,
    input  logic                            i_cfg_we,
    input  logic [smdf_pkg::CFG_AW-1:0]      i_cfg_addr,
    input  logic [smdf_pkg::CFG_DW-1:0]      i_cfg_data
);

    localparam int SW  = SAMPLE_BITS;
    localparam int DW  = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int MW  = smdf_pkg::MUL_W;
    localparam int PW  = 2 * MW;
    localparam int LW  = $clog2(DELAY_DEPTH + 1);
    localparam int IW  = $clog2(DELAY_DEPTH);
    localparam int AW  = $clog2(2 * DELAY_DEPTH);
    localparam int SB  = $clog2(SINE_TABLE_DEPTH);
    localparam int MEM_N = 2 * DELAY_DEPTH;

    localparam logic signed [PW-1:0] P_RND  = PW'(32768);
    localparam logic signed [PW-1:0] P_SMAX = (PW'(1) <<< (SW - 1)) - PW'(1);
    localparam logic signed [PW-1:0] P_SMIN = -P_SMAX - PW'(1);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_INC, S_X2, S_P7, S_P5, S_P3, S_SIN, S_MOD,
        S_DLY, S_ADR, S_WR, S_MW, S_SUM, S_OUT
    } t_state;

    function automatic logic signed [SW-1:0] sat_s(input logic signed [PW-1:0] v);
        logic signed [PW-1:0] c;
        c = (v > P_SMAX) ? P_SMAX : ((v < P_SMIN) ? P_SMIN : v);
        return c[SW-1:0];
    endfunction

    t_state r_state;

    // configuration
    logic [30:0] r_lfo_step;
    logic [15:0] r_fb_gain;
    logic [16:0] r_mod_depth;
    logic [16:0] r_wet_mix;
    logic [12:0] r_delay_len;

    // channel state
    logic [IW-1:0]          r_wi_l, r_wi_r;
    logic [31:0]            r_ph_l, r_ph_r;
    logic signed [SW-1:0]   r_lw_l, r_lw_r;

    // item working registers
    logic signed [SW-1:0]   r_x_in;
    logic                   r_ch;
    logic [30:0]            r_x;
    logic [1:0]             r_quad;
    logic [30:0]            r_x2;
    logic [IW-1:0]          r_w;
    logic signed [PW-1:0]   r_prod;
    logic signed [PW-1:0]   r_acc;
    logic signed [SW-1:0]   r_rdata;
    logic signed [SW-1:0]   r_out;
    logic                   r_out_ch;
    logic [AW-1:0]          r_clr;

    logic signed [SW-1:0]   mem [MEM_N];

    // clamped configuration
    logic [LW-1:0]  len;
    logic [15:0]    gain;
    logic [16:0]    depth;
    logic [16:0]    mix;
    logic [LW-1:0]  len_dist;
    logic           len_ge8;

    always_comb begin
        len   = ({19'd0, r_delay_len} > 32'(DELAY_DEPTH)) ? LW'(DELAY_DEPTH)
                                                          : LW'(r_delay_len);
        gain  = (r_fb_gain > smdf_pkg::GAIN_MAX) ? smdf_pkg::GAIN_MAX : r_fb_gain;
        depth = (r_mod_depth > smdf_pkg::Q16_ONE) ? smdf_pkg::Q16_ONE : r_mod_depth;
        mix   = (r_wet_mix > smdf_pkg::Q16_ONE) ? smdf_pkg::Q16_ONE : r_wet_mix;
        len_ge8  = (len >= LW'(8));
        len_dist = len_ge8 ? (len - LW'(8)) : (LW'(8) - len);
    end

    // intake: phase to quarter-wave argument
    logic               s_acc;
    logic [31:0]        ph_sel;
    logic [31:0]        ph_u;
    logic [30:0]        x_arg;
    logic signed [SW-1:0] x_new;

    assign s_axis_tready = (r_state == S_IDLE);
    assign s_acc  = s_axis_tvalid && s_axis_tready;
    assign x_new  = s_axis_tdata[SW-1:0];
    assign ph_sel = s_axis_tuser ? r_ph_r : r_ph_l;
    assign ph_u   = {ph_sel[31:32-SB], {(32 - SB){1'b0}}};
    assign x_arg  = ph_u[30] ? (smdf_pkg::Q30_ONE - {1'b0, ph_u[29:0]})
                             : {1'b0, ph_u[29:0]};

    // polynomial / sine / delay / increment / feedback / mix terms from the last product
    logic [30:0]    prod_q30;
    logic [30:0]    p_cur;
    logic [31:0]    sin_rnd;
    logic [16:0]    sin_mag;
    logic [16:0]    mod_val;
    logic [LW-1:0]  dly;
    logic [IW-1:0]  w_cur;
    logic [IW-1:0]  wp_sel;
    logic [LW:0]    rd_t;
    logic [LW:0]    rd_w;
    logic [IW-1:0]  rd_idx;
    logic [31:0]    inc;
    logic signed [PW-1:0] fb_sum;
    logic signed [PW-1:0] mix_sum;

    always_comb begin
        prod_q30 = r_prod[60:30];
        p_cur    = '0;
        unique case (r_state)
            S_P5:    p_cur = smdf_pkg::CO5 - prod_q30;
            S_P3:    p_cur = smdf_pkg::CO3 - prod_q30;
            S_SIN:   p_cur = smdf_pkg::CO1 - prod_q30;
            default: p_cur = '0;
        endcase
        sin_rnd = {1'b0, prod_q30} + 32'd16384;
        sin_mag = (sin_rnd[31:15] > 17'd32767) ? 17'd32767 : sin_rnd[31:15];
        mod_val = r_quad[1] ? (smdf_pkg::Q16_HALF - sin_mag)
                            : (smdf_pkg::Q16_HALF + sin_mag);

        // delay is 1 + prod*(len-8)/2^34, or for short lengths 1 only when prod is 0
        if (len_ge8) begin
            dly = LW'(1) + LW'(r_prod[PW-2:34]);
        end else begin
            dly = (r_prod == '0) ? LW'(1) : LW'(0);
        end
        wp_sel = r_ch ? r_wi_r : r_wi_l;
        w_cur  = (LW'(wp_sel) < len) ? wp_sel : IW'(0);
        rd_t   = (LW+1)'(w_cur) + (LW+1)'(len) - (LW+1)'(dly);
        rd_w   = (rd_t >= (LW+1)'(len)) ? (rd_t - (LW+1)'(len)) : rd_t;
        rd_idx = rd_w[IW-1:0];

        inc     = r_ch ? ({1'b0, r_lfo_step} + 32'(r_prod[PW-2:32]))
                       : {1'b0, r_lfo_step};
        fb_sum  = PW'(r_x_in) + ((r_prod + P_RND) >>> 16);
        mix_sum = (r_acc + r_prod + P_RND) >>> 16;
    end

    // shared multiplier operands
    logic signed [MW-1:0] op_a, op_b;

    always_comb begin
        unique case (r_state)
            S_INC: begin
                op_a = MW'(r_lfo_step[30:2]);
                op_b = MW'(smdf_pkg::DIV5_MAGIC);
            end
            S_X2: begin
                op_a = MW'(r_x);
                op_b = MW'(r_x);
            end
            S_P7: begin
                op_a = MW'(prod_q30);
                op_b = MW'(smdf_pkg::CO7);
            end
            S_P5, S_P3: begin
                op_a = MW'(r_x2);
                op_b = MW'(p_cur);
            end
            S_SIN: begin
                op_a = MW'(r_x);
                op_b = MW'(p_cur);
            end
            S_MOD: begin
                op_a = MW'(mod_val);
                op_b = MW'(depth);
            end
            S_DLY: begin
                op_a = MW'(r_prod[31:0]);
                op_b = MW'(len_dist);
            end
            S_ADR: begin
                op_a = MW'(r_ch ? r_lw_r : r_lw_l);
                op_b = MW'(gain);
            end
            S_WR: begin
                op_a = MW'(r_x_in);
                op_b = MW'(18'(smdf_pkg::Q16_ONE) - 18'(mix));
            end
            S_MW: begin
                op_a = MW'(r_rdata);
                op_b = MW'(mix);
            end
            default: begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    // delay memory port
    logic           mem_we;
    logic [AW-1:0]  mem_waddr;
    logic signed [SW-1:0] mem_wdata;
    logic           mem_re;
    logic [AW-1:0]  mem_raddr;
    logic [AW-1:0]  base;

    always_comb begin
        base      = r_ch ? AW'(len) : AW'(0);
        mem_we    = (r_state == S_CLEAR) || (r_state == S_WR);
        mem_waddr = (r_state == S_CLEAR) ? r_clr : (base + AW'(r_w));
        mem_wdata = (r_state == S_CLEAR) ? '0 : sat_s(fb_sum);
        mem_re    = (r_state == S_ADR);
        mem_raddr = base + AW'(rd_idx);
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= mem[mem_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= op_a * op_b;
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_lfo_step  <= '0;
            r_fb_gain   <= '0;
            r_mod_depth <= smdf_pkg::Q16_HALF;
            r_wet_mix   <= smdf_pkg::Q16_HALF;
            r_delay_len <= '0;
            r_wi_l      <= '0;
            r_wi_r      <= '0;
            r_ph_l      <= '0;
            r_ph_r      <= '0;
            r_lw_l      <= '0;
            r_lw_r      <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    smdf_pkg::CFG_LFO_STEP:  r_lfo_step  <= i_cfg_data[30:0];
                    smdf_pkg::CFG_FB_GAIN:   r_fb_gain   <= i_cfg_data[15:0];
                    smdf_pkg::CFG_MOD_DEPTH: r_mod_depth <= i_cfg_data[16:0];
                    smdf_pkg::CFG_WET_MIX:   r_wet_mix   <= i_cfg_data[16:0];
                    smdf_pkg::CFG_DELAY_LEN: r_delay_len <= i_cfg_data[12:0];
                    default: ;
                endcase
            end

            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + AW'(1);
                    if (r_clr == AW'(MEM_N - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (s_acc) begin
                        r_x_in   <= x_new;
                        r_ch     <= s_axis_tuser;
                        r_out_ch <= s_axis_tuser;
                        r_x      <= x_arg;
                        r_quad   <= ph_u[31:30];
                        if (len == '0) begin
                            r_out   <= x_new;
                            r_state <= S_OUT;
                        end else begin
                            r_state <= S_INC;
                        end
                    end
                end
                S_INC: r_state <= S_X2;
                S_X2: begin
                    if (r_ch) begin
                        r_ph_r <= r_ph_r + inc;
                    end else begin
                        r_ph_l <= r_ph_l + inc;
                    end
                    r_state <= S_P7;
                end
                S_P7: begin
                    r_x2    <= prod_q30;
                    r_state <= S_P5;
                end
                S_P5:  r_state <= S_P3;
                S_P3:  r_state <= S_SIN;
                S_SIN: r_state <= S_MOD;
                S_MOD: r_state <= S_DLY;
                S_DLY: r_state <= S_ADR;
                S_ADR: begin
                    r_w     <= w_cur;
                    r_state <= S_WR;
                end
                S_WR: begin
                    if (r_ch) begin
                        r_wi_r <= (LW'(r_w) + LW'(1) == len) ? '0 : r_w + IW'(1);
                    end else begin
                        r_wi_l <= (LW'(r_w) + LW'(1) == len) ? '0 : r_w + IW'(1);
                    end
                    r_state <= S_MW;
                end
                S_MW: begin
                    r_acc <= r_prod;
                    if (r_ch) begin
                        r_lw_r <= r_rdata;
                    end else begin
                        r_lw_l <= r_rdata;
                    end
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    r_out   <= sat_s(mix_sum);
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (m_axis_tready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = (r_state == S_OUT);
    assign m_axis_tdata  = DW'($unsigned(r_out));
    assign m_axis_tuser  = r_out_ch;

    // one sample in flight at a time
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> !m_axis_tvalid)
        else $error("request accepted while result pending");

    a_clear_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !s_axis_tready)
        else $error("request taken during clearing pass");

    a_rd_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ADR) |-> (LW'(rd_idx) < len && LW'(w_cur) < len))
        else $error("delay index out of range");

    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> ($past(r_state) == S_SUM || $past(r_state) == S_IDLE))
        else $error("result raised from unexpected step");

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the stereo flanger: directed table with bypass,
// clamping, short and stale delay cases, then randomized samples over several
// register settings and idle/stall mixes, checked against a local predictor.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int DEPTH = 4096;

    typedef struct packed {
        logic signed [23:0] smp;
        logic               ch;
    } t_audio;

    typedef struct {
        bit                 is_cfg;
        smdf_pkg::t_cfg_idx idx;
        logic [30:0]        val;
        logic [23:0]        smp;
        bit                 ch;
        bit                 known;
        logic [23:0]        res;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [23:0] s_axis_tdata = '0;
    logic s_axis_tuser = 1'b0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;
    logic m_axis_tuser;
    logic i_cfg_we = 1'b0;
    logic [smdf_pkg::CFG_AW-1:0] i_cfg_addr = '0;
    logic [smdf_pkg::CFG_DW-1:0] i_cfg_data = '0;

    stereo_modulated_delay_flanger_top uut (.*);

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("Verification failed");
        $finish;
    end

    // predictor state
    logic signed [23:0] dly_mem [0:2*DEPTH-1];
    logic [11:0]        wr_pos [2];
    logic [31:0]        lfo_ph [2];
    logic signed [23:0] prev_wet [2];
    logic [30:0] step_r;
    logic [15:0] gain_r;
    logic [16:0] depth_r, mix_r;
    logic [12:0] len_r;

    t_audio   expect_q [$];
    bit       typed_ok_q [$];
    logic [23:0] typed_q [$];
    int  n_err = 0, n_res = 0, n_acc = 0;
    int  send_idle = 0, recv_stall = 0;

    initial begin
        for (int i = 0; i < 2*DEPTH; i++) dly_mem[i] = '0;
        wr_pos = '{0, 0};
        lfo_ph = '{0, 0};
        prev_wet = '{0, 0};
        step_r = '0;
        gain_r = '0;
        depth_r = 17'd32768;
        mix_r = 17'd32768;
        len_r = '0;
    end

    function automatic longint sine_q15(logic [31:0] ph);
        longint unsigned x, x2, p, y;
        logic [1:0] quad;
        quad = ph[31:30];
        x = {34'd0, ph[29:22], 22'd0};
        if (quad[0]) x = 64'd1073741824 - x;
        x2 = (x * x) >> 30;
        p = 64'd5026995;
        p = 64'd85569306 - ((x2 * p) >> 30);
        p = 64'd693598670 - ((x2 * p) >> 30);
        p = 64'd1686629713 - ((x2 * p) >> 30);
        y = (((x * p) >> 30) + 64'd16384) >> 15;
        if (y > 32767) y = 32767;
        return quad[1] ? -longint'(y) : longint'(y);
    endfunction

    function automatic longint clip24(longint v);
        if (v > 8388607) return 8388607;
        if (v < -8388608) return -8388608;
        return v;
    endfunction

    function automatic logic [23:0] flange(logic signed [23:0] smp, bit ch);
        longint x, wet, fb, y;
        longint unsigned m, prod, neg, len, gain, dep, mix, inc, d, w, rd, base;
        x = smp;
        len = (len_r > DEPTH) ? DEPTH : len_r;
        if (len == 0) return smp;
        gain = (gain_r > 62259) ? 62259 : gain_r;
        dep = (depth_r > 65536) ? 65536 : depth_r;
        mix = (mix_r > 65536) ? 65536 : mix_r;
        base = ch ? len : 0;
        m = longint'(sine_q15(lfo_ph[ch]) + 32768);
        inc = ch ? (longint'(step_r) * 21) / 20 : step_r;
        lfo_ph[ch] = lfo_ph[ch] + inc[31:0];
        prod = m * dep;
        if (len >= 8) begin
            d = 1 + ((prod * (len - 8)) >> 34);
        end else begin
            neg = prod * (8 - len);
            d = (neg >= 64'h4_0000_0000) ? 0 : ((64'h4_0000_0000 - neg) >> 34);
        end
        w = (wr_pos[ch] < len) ? wr_pos[ch] : 0;
        rd = (w + len - d) % len;
        wet = dly_mem[base + rd];
        fb = clip24(x + ((longint'(prev_wet[ch]) * longint'(gain) + 32768) >>> 16));
        dly_mem[base + w] = fb[23:0];
        wr_pos[ch] = (w + 1 == len) ? 12'd0 : 12'(w + 1);
        prev_wet[ch] = wet[23:0];
        y = clip24((x * longint'(65536 - mix) + wet * longint'(mix) + 32768) >>> 16);
        return y[23:0];
    endfunction

    // register shadow
    always @(posedge i_clk) begin
        if (i_rst_n && i_cfg_we) begin
            case (smdf_pkg::t_cfg_idx'(i_cfg_addr))
                smdf_pkg::CFG_LFO_STEP:  step_r <= i_cfg_data[30:0];
                smdf_pkg::CFG_FB_GAIN:   gain_r <= i_cfg_data[15:0];
                smdf_pkg::CFG_MOD_DEPTH: depth_r <= i_cfg_data[16:0];
                smdf_pkg::CFG_WET_MIX:   mix_r <= i_cfg_data[16:0];
                smdf_pkg::CFG_DELAY_LEN: len_r <= i_cfg_data[12:0];
                default: ;
            endcase
        end
    end

    // request side: predict on acceptance
    always @(posedge i_clk) begin
        logic [23:0] pred;
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            pred = flange(s_axis_tdata, s_axis_tuser);
            if (typed_ok_q.pop_front()) pred = typed_q[0];
            void'(typed_q.pop_front());
            expect_q.push_back('{pred, s_axis_tuser});
            n_acc++;
        end
    end

    // result side
    always @(posedge i_clk) begin
        t_audio exp_r;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            n_res++;
            if (expect_q.size() == 0) begin
                n_err++;
                if (n_err <= 10) $display("ERROR: unexpected result %h ch %0d",
                                          m_axis_tdata, m_axis_tuser);
            end else begin
                exp_r = expect_q.pop_front();
                if (m_axis_tdata !== exp_r.smp || m_axis_tuser !== exp_r.ch) begin
                    n_err++;
                    if (n_err <= 10)
                        $display("ERROR: result %0d exp %h/%0d got %h/%0d", n_res,
                                 exp_r.smp, exp_r.ch, m_axis_tdata, m_axis_tuser);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall);
    end

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (expect_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);    // let the block settle
    endtask

    task automatic write_reg(smdf_pkg::t_cfg_idx idx, logic [30:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send(logic [23:0] smp, bit ch, bit known, logic [23:0] res);
        if ($urandom_range(99) < send_idle) begin
            s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle);
        end
        typed_ok_q.push_back(known);
        typed_q.push_back(res);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= smp;
        s_axis_tuser <= ch;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    t_row dir_rows [] = '{
        '{0, smdf_pkg::CFG_LFO_STEP, 0, 24'h7FFFFF, 0, 1, 24'h7FFFFF},   // bypass
        '{0, smdf_pkg::CFG_LFO_STEP, 0, 24'h800000, 1, 1, 24'h800000},
        '{0, smdf_pkg::CFG_LFO_STEP, 0, 24'h000000, 0, 1, 24'h000000},
        '{0, smdf_pkg::CFG_LFO_STEP, 0, 24'hFFFFFF, 1, 1, 24'hFFFFFF},
        '{0, smdf_pkg::CFG_LFO_STEP, 0, 24'h555555, 0, 1, 24'h555555},
        '{1, smdf_pkg::CFG_DELAY_LEN, 1, 0, 0, 0, 0},                    // zero delay
        '{1, smdf_pkg::CFG_FB_GAIN, 31'hFFFF, 0, 0, 0, 0},               // gain clamps
        '{0, smdf_pkg::CFG_LFO_STEP, 0, 24'h7FFFFF, 0, 0, 0},
        '{0, smdf_pkg::CFG_LFO_STEP, 0, 24'h7FFFFF, 0, 0, 0},
        '{0, smdf_pkg::CFG_LFO_STEP, 0, 24'h800000, 1, 0, 0},
        '{0, smdf_pkg::CFG_LFO_STEP, 0, 24'h800000, 1, 0, 0},
        '{1, smdf_pkg::CFG_DELAY_LEN, 31'h1FFF, 0, 0, 0, 0},             // length clamps
        '{1, smdf_pkg::CFG_MOD_DEPTH, 31'h1FFFF, 0, 0, 0, 0},
        '{1, smdf_pkg::CFG_WET_MIX, 31'h1FFFF, 0, 0, 0, 0},
        '{1, smdf_pkg::CFG_LFO_STEP, 31'h7FFFFFFF, 0, 0, 0, 0},
        '{0, smdf_pkg::CFG_LFO_STEP, 0, 24'h2AAAAA, 0, 0, 0},
        '{0, smdf_pkg::CFG_LFO_STEP, 0, 24'hD55555, 1, 0, 0},
        '{0, smdf_pkg::CFG_LFO_STEP, 0, 24'h123456, 0, 0, 0},
        '{1, smdf_pkg::CFG_DELAY_LEN, 3, 0, 0, 0, 0},                    // stale write index
        '{0, smdf_pkg::CFG_LFO_STEP, 0, 24'h400000, 0, 0, 0},
        '{0, smdf_pkg::CFG_LFO_STEP, 0, 24'hC00000, 1, 0, 0},
        '{1, smdf_pkg::CFG_WET_MIX, 0, 0, 0, 0, 0},                      // fully dry
        '{1, smdf_pkg::CFG_MOD_DEPTH, 0, 0, 0, 0, 0},
        '{0, smdf_pkg::CFG_LFO_STEP, 0, 24'h7FFFFF, 1, 0, 0},
        '{0, smdf_pkg::CFG_LFO_STEP, 0, 24'h000001, 0, 0, 0}
    };

    initial begin
        int idle_mode [4][2];
        logic [12:0] lens [6];
        idle_mode = '{'{0, 0}, '{81, 0}, '{0, 81}, '{34, 34}};
        lens = '{13'd8, 13'd5, 13'd64, 13'd4096, 13'd2, 13'd300};
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i]) begin
            if (dir_rows[i].is_cfg) begin
                drain();
                write_reg(dir_rows[i].idx, dir_rows[i].val);
            end else begin
                send(dir_rows[i].smp, dir_rows[i].ch, dir_rows[i].known, dir_rows[i].res);
            end
        end

        for (int ph = 0; ph < 4; ph++) begin
            for (int sub = 0; sub < 2; sub++) begin
                drain();
                send_idle = idle_mode[ph][0];
                recv_stall = idle_mode[ph][1];
                write_reg(smdf_pkg::CFG_LFO_STEP,
                          (ph == 3 && sub == 1) ? 31'h7FFFFFFF : 31'($urandom()));
                write_reg(smdf_pkg::CFG_FB_GAIN,
                          (ph == 1) ? 31'd62259 : 31'($urandom_range(65535)));
                write_reg(smdf_pkg::CFG_MOD_DEPTH,
                          (ph == 2) ? 31'd65536 : 31'($urandom_range(70000)));
                write_reg(smdf_pkg::CFG_WET_MIX,
                          (sub == 0) ? 31'd65536 : 31'($urandom_range(70000)));
                write_reg(smdf_pkg::CFG_DELAY_LEN,
                          31'((ph == 0 && sub == 1) ? 13'd0 : lens[(ph*2+sub) % 6]));
                for (int k = 0; k < 156; k++) begin
                    if (ph == 2 && sub == 0 && k == 80) begin
                        // hold off until the block has nothing outstanding
                        s_axis_tvalid <= 1'b0;
                        @(posedge i_clk);
                        while (expect_q.size() != 0) @(posedge i_clk);
                    end
                    send(24'($urandom()), 1'($urandom_range(1)), 0, 0);
                end
            end
        end

        drain();
        repeat (30) @(posedge i_clk);
        $display("Run covered %0d samples over bypass, short, clamped and long delays,", n_acc);
        $display("%0d results checked under four idle/stall mixes, %0d mismatches.",
                 n_res, n_err);
        if (n_err == 0 && expect_q.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

/* stereo_modulated_delay_flanger_top.f */
src/smdf_pkg.sv
src/stereo_modulated_delay_flanger_top.sv
sim/tb_top.sv
